### design/rqi_pkg.sv
// ----------------------------------------------------------------------------
// rqi_pkg: shared types, constants and helpers for the ray/quadric unit
// Widths of the quadratic coefficients, discriminant, root and divider
// cells, plus the clamp, magnitude and divide-step helpers.
// ----------------------------------------------------------------------------
package rqi_pkg;

   localparam int FRAC_BITS_DEF = 16;

   // coefficient and intermediate widths
   localparam int ABC_W    = 61;
   localparam int MAG_W    = 60;
   localparam int TERM_W   = 64;
   localparam int WIDE_W   = 96;
   localparam int DISC_W   = 124;
   localparam int SQ_W     = 62;
   localparam int SQ_REM_W = 64;
   localparam int DIV_W    = 62;
   localparam int Q_W      = 32;

   localparam logic signed [ABC_W-1:0] LIM = {1'b0, {(ABC_W-1){1'b1}}};

   localparam logic [Q_W-1:0] Q_POS_MAX = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic [Q_W-1:0] Q_NEG_MAG = {1'b1, {(Q_W-1){1'b0}}};

   // object kinds
   localparam logic [1:0] SHP_SPHERE = 2'd0;
   localparam logic [1:0] SHP_CYL    = 2'd1;
   localparam logic [1:0] SHP_CONE   = 2'd2;

   // result status
   localparam logic [1:0] ST_MISS  = 2'd0;
   localparam logic [1:0] ST_HIT   = 2'd1;
   localparam logic [1:0] ST_DEGEN = 2'd2;

   typedef struct packed {
      logic                    valid;
      logic                    shape_ok;
      logic signed [ABC_W-1:0] a;
      logic signed [ABC_W-1:0] b;
      logic signed [ABC_W-1:0] c;
   } abc_type;

   typedef struct packed {
      logic                    valid;
      logic [1:0]              status;
      logic signed [ABC_W-1:0] a;
      logic signed [ABC_W-1:0] b;
   } sq_tag_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] status;
   } div_ctl_type;

   typedef struct packed {
      logic             neg;
      logic             ovf;
      logic [DIV_W-1:0] rem;
      logic [Q_W-1:0]   lo;
      logic [Q_W-1:0]   q;
   } div_lane_type;

   typedef struct packed {
      div_lane_type near;
      div_lane_type far;
   } div_pair_type;

   // clamp a wide signed value to +-LIM
   function automatic logic signed [ABC_W-1:0] sat_abc(input logic signed [WIDE_W-1:0] x);
      logic signed [WIDE_W-1:0] lim_w;
      lim_w = WIDE_W'(LIM);
      if (x > lim_w) begin
         sat_abc = LIM;
      end else if (x < -lim_w) begin
         sat_abc = -LIM;
      end else begin
         sat_abc = x[ABC_W-1:0];
      end
   endfunction

   // magnitude of a clamped coefficient
   function automatic logic [MAG_W-1:0] mag_abc(input logic signed [ABC_W-1:0] x);
      logic [ABC_W-1:0] t;
      t = x[ABC_W-1] ? (~x + 1'b1) : x;
      return t[MAG_W-1:0];
   endfunction

   // one restoring divide step: shift in one dividend bit, emit one quotient bit
   function automatic div_lane_type div_step(input div_lane_type l,
                                             input logic [DIV_W-1:0] d);
      logic [DIV_W:0] r2;
      logic [DIV_W:0] dif;
      logic           ge;
      div_lane_type   o;
      r2  = {l.rem, l.lo[Q_W-1]};
      dif = r2 - {1'b0, d};
      ge  = (r2 >= {1'b0, d});
      o     = l;
      o.rem = ge ? dif[DIV_W-1:0] : r2[DIV_W-1:0];
      o.lo  = {l.lo[Q_W-2:0], 1'b0};
      o.q   = {l.q[Q_W-2:0], ge};
      return o;
   endfunction

endpackage

### design/rqi_front.sv
// ----------------------------------------------------------------------------
// rqi_front: quadratic coefficient pipeline
// Forms v = origin - center, the fixed-point products, the cone slope
// products and the clamped a, b, c of the quadratic. Five stages.
// ----------------------------------------------------------------------------
module rqi_front #(
   parameter int FRAC_BITS = rqi_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [1:0]          shape,
   input  logic signed [31:0]  ctr_x,
   input  logic signed [31:0]  ctr_y,
   input  logic signed [31:0]  ctr_z,
   input  logic [30:0]         shape_coef,
   input  logic signed [31:0]  org_x,
   input  logic signed [31:0]  org_y,
   input  logic signed [31:0]  org_z,
   input  logic signed [31:0]  dir_x,
   input  logic signed [31:0]  dir_y,
   input  logic signed [31:0]  dir_z,
   output rqi_pkg::abc_type    abc
);

   localparam int TW = rqi_pkg::TERM_W;
   localparam int WW = rqi_pkg::WIDE_W;
   localparam int AW = rqi_pkg::ABC_W;
   localparam int AX = 0;
   localparam int AY = 1;
   localparam int AZ = 2;

   // stage 1: ray relative to object
   logic                s1_valid_ff;
   logic [1:0]          s1_shape_ff;
   logic [30:0]         s1_coef_ff;
   logic signed [32:0]  s1_d_ff [3];
   logic signed [32:0]  s1_v_ff [3];
   logic signed [32:0]  s1_d_in [3];
   logic signed [32:0]  s1_v_in [3];

   always_comb begin
      s1_d_in[AX] = 33'(dir_x);
      s1_d_in[AY] = 33'(dir_y);
      s1_d_in[AZ] = 33'(dir_z);
      s1_v_in[AX] = 33'(org_x) - 33'(ctr_x);
      s1_v_in[AY] = 33'(org_y) - 33'(ctr_y);
      s1_v_in[AZ] = 33'(org_z) - 33'(ctr_z);
   end

   always_ff @(posedge clock) begin
      s1_valid_ff <= in_valid && !reset;
      s1_shape_ff <= shape;
      s1_coef_ff  <= shape_coef;
      for (int i = 0; i < 3; i++) begin
         s1_d_ff[i] <= s1_d_in[i];
         s1_v_ff[i] <= s1_v_in[i];
      end
   end

   // stage 2: floor-rounded products
   logic                s2_valid_ff;
   logic [1:0]          s2_shape_ff;
   logic [30:0]         s2_coef_ff;
   logic signed [65:0]  p_dd [3];
   logic signed [65:0]  p_dv [3];
   logic signed [65:0]  p_vv [3];
   logic signed [TW-1:0] s2_dd_ff [3];
   logic signed [TW-1:0] s2_dv_ff [3];
   logic signed [TW-1:0] s2_vv_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p_dd[i] = s1_d_ff[i] * s1_d_ff[i];
         p_dv[i] = s1_d_ff[i] * s1_v_ff[i];
         p_vv[i] = s1_v_ff[i] * s1_v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      s2_valid_ff <= s1_valid_ff && !reset;
      s2_shape_ff <= s1_shape_ff;
      s2_coef_ff  <= s1_coef_ff;
      for (int i = 0; i < 3; i++) begin
         s2_dd_ff[i] <= TW'(p_dd[i] >>> FRAC_BITS);
         s2_dv_ff[i] <= TW'(p_dv[i] >>> FRAC_BITS);
         s2_vv_ff[i] <= TW'(p_vv[i] >>> FRAC_BITS);
      end
   end

   // stage 3: slope times y terms, split into two partial products
   logic                 s3_valid_ff;
   logic [1:0]           s3_shape_ff;
   logic [30:0]          s3_coef_ff;
   logic signed [TW-1:0] yq [3];
   logic [62:0]          s3_lo_in [3];
   logic signed [63:0]   s3_hi_in [3];
   logic [62:0]          s3_lo_ff [3];
   logic signed [63:0]   s3_hi_ff [3];
   logic signed [TW-1:0] s3_dd_ff [3];
   logic signed [TW-1:0] s3_dv_ff [3];
   logic signed [TW-1:0] s3_vv_ff [3];

   always_comb begin
      yq[0] = s2_dd_ff[AY];
      yq[1] = s2_dv_ff[AY];
      yq[2] = s2_vv_ff[AY];
      for (int k = 0; k < 3; k++) begin
         s3_lo_in[k] = s2_coef_ff * yq[k][31:0];
         s3_hi_in[k] = $signed({1'b0, s2_coef_ff}) * $signed(yq[k][63:32]);
      end
   end

   always_ff @(posedge clock) begin
      s3_valid_ff <= s2_valid_ff && !reset;
      s3_shape_ff <= s2_shape_ff;
      s3_coef_ff  <= s2_coef_ff;
      for (int i = 0; i < 3; i++) begin
         s3_lo_ff[i] <= s3_lo_in[i];
         s3_hi_ff[i] <= s3_hi_in[i];
         s3_dd_ff[i] <= s2_dd_ff[i];
         s3_dv_ff[i] <= s2_dv_ff[i];
         s3_vv_ff[i] <= s2_vv_ff[i];
      end
   end

   // stage 4: join partials, round and clamp the slope terms
   logic                 s4_valid_ff;
   logic [1:0]           s4_shape_ff;
   logic [30:0]          s4_coef_ff;
   logic signed [WW-1:0] kw [3];
   logic signed [AW-1:0] s4_k_in [3];
   logic signed [AW-1:0] s4_k_ff [3];
   logic signed [TW-1:0] s4_dd_ff [3];
   logic signed [TW-1:0] s4_dv_ff [3];
   logic signed [TW-1:0] s4_vv_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         kw[k] = $signed({s3_hi_ff[k], 32'd0}) + $signed({33'd0, s3_lo_ff[k]});
         s4_k_in[k] = rqi_pkg::sat_abc(kw[k] >>> FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      s4_valid_ff <= s3_valid_ff && !reset;
      s4_shape_ff <= s3_shape_ff;
      s4_coef_ff  <= s3_coef_ff;
      for (int i = 0; i < 3; i++) begin
         s4_k_ff[i]  <= s4_k_in[i];
         s4_dd_ff[i] <= s3_dd_ff[i];
         s4_dv_ff[i] <= s3_dv_ff[i];
         s4_vv_ff[i] <= s3_vv_ff[i];
      end
   end

   // stage 5: sum per shape and clamp a, b, c
   rqi_pkg::abc_type     abc_ff;
   rqi_pkg::abc_type     abc_in;
   logic signed [WW-1:0] sa;
   logic signed [WW-1:0] sb;
   logic signed [WW-1:0] sc;
   logic signed [WW-1:0] coef_w;
   logic signed [WW-1:0] xz_a;
   logic signed [WW-1:0] xz_b;
   logic signed [WW-1:0] xz_c;

   always_comb begin
      coef_w = $signed({{(WW-31){1'b0}}, s4_coef_ff});
      xz_a   = WW'(s4_dd_ff[AX]) + WW'(s4_dd_ff[AZ]);
      xz_b   = WW'(s4_dv_ff[AX]) + WW'(s4_dv_ff[AZ]);
      xz_c   = WW'(s4_vv_ff[AX]) + WW'(s4_vv_ff[AZ]);
      sa = '0;
      sb = '0;
      sc = '0;
      abc_in.shape_ok = 1'b1;
      case (s4_shape_ff)
         rqi_pkg::SHP_SPHERE: begin
            sa = xz_a + WW'(s4_dd_ff[AY]);
            sb = xz_b + WW'(s4_dv_ff[AY]);
            sc = xz_c + WW'(s4_vv_ff[AY]) - coef_w;
         end
         rqi_pkg::SHP_CYL: begin
            sa = xz_a;
            sb = xz_b;
            sc = xz_c - coef_w;
         end
         rqi_pkg::SHP_CONE: begin
            sa = xz_a - WW'(s4_k_ff[0]);
            sb = xz_b - WW'(s4_k_ff[1]);
            sc = xz_c - WW'(s4_k_ff[2]);
         end
         default: begin
            abc_in.shape_ok = 1'b0;
         end
      endcase
      // drop the valid flag while in reset
      abc_in.valid = s4_valid_ff && !reset;
      abc_in.a     = rqi_pkg::sat_abc(sa);
      abc_in.b     = rqi_pkg::sat_abc(sb + sb);
      abc_in.c     = rqi_pkg::sat_abc(sc);
   end

   always_ff @(posedge clock) begin
      abc_ff <= abc_in;
   end

   assign abc = abc_ff;

endmodule

### design/rqi_disc.sv
// ----------------------------------------------------------------------------
// rqi_disc: discriminant pipeline
// Squares b and multiplies a by c from 32-bit partial products, then forms
// b^2 - 4ac and the hit status. Three stages.
// ----------------------------------------------------------------------------
module rqi_disc (
   input  logic                              clock,
   input  logic                              reset,
   input  rqi_pkg::abc_type                  abc,
   output rqi_pkg::sq_tag_type               tag,
   output logic [rqi_pkg::DISC_W-1:0]        disc
);

   localparam int MW = rqi_pkg::MAG_W;
   localparam int DW = rqi_pkg::DISC_W;

   // stage 1: partial products of the magnitudes
   logic          d1_valid_ff;
   logic          d1_ok_ff;
   logic          d1_azero_ff;
   logic          d1_acneg_ff;
   logic signed [rqi_pkg::ABC_W-1:0] d1_a_ff;
   logic signed [rqi_pkg::ABC_W-1:0] d1_b_ff;
   logic [MW-1:0] ma;
   logic [MW-1:0] mb;
   logic [MW-1:0] mc;
   logic [63:0]   bb_ll_in;
   logic [59:0]   bb_lh_in;
   logic [55:0]   bb_hh_in;
   logic [63:0]   ac_ll_in;
   logic [59:0]   ac_lh_in;
   logic [59:0]   ac_hl_in;
   logic [55:0]   ac_hh_in;
   logic [63:0]   bb_ll_ff;
   logic [59:0]   bb_lh_ff;
   logic [55:0]   bb_hh_ff;
   logic [63:0]   ac_ll_ff;
   logic [59:0]   ac_lh_ff;
   logic [59:0]   ac_hl_ff;
   logic [55:0]   ac_hh_ff;

   always_comb begin
      ma = rqi_pkg::mag_abc(abc.a);
      mb = rqi_pkg::mag_abc(abc.b);
      mc = rqi_pkg::mag_abc(abc.c);
      bb_ll_in = mb[31:0] * mb[31:0];
      bb_lh_in = mb[31:0] * mb[MW-1:32];
      bb_hh_in = mb[MW-1:32] * mb[MW-1:32];
      ac_ll_in = ma[31:0] * mc[31:0];
      ac_lh_in = ma[31:0] * mc[MW-1:32];
      ac_hl_in = ma[MW-1:32] * mc[31:0];
      ac_hh_in = ma[MW-1:32] * mc[MW-1:32];
   end

   always_ff @(posedge clock) begin
      d1_valid_ff <= abc.valid && !reset;
      d1_ok_ff    <= abc.shape_ok;
      d1_azero_ff <= (abc.a == '0);
      d1_acneg_ff <= (abc.a[rqi_pkg::ABC_W-1] != abc.c[rqi_pkg::ABC_W-1]) && (abc.c != '0);
      d1_a_ff     <= abc.a;
      d1_b_ff     <= abc.b;
      bb_ll_ff    <= bb_ll_in;
      bb_lh_ff    <= bb_lh_in;
      bb_hh_ff    <= bb_hh_in;
      ac_ll_ff    <= ac_ll_in;
      ac_lh_ff    <= ac_lh_in;
      ac_hl_ff    <= ac_hl_in;
      ac_hh_ff    <= ac_hh_in;
   end

   // stage 2: full b^2 and 4ac
   logic          d2_valid_ff;
   logic          d2_ok_ff;
   logic          d2_azero_ff;
   logic          d2_acneg_ff;
   logic signed [rqi_pkg::ABC_W-1:0] d2_a_ff;
   logic signed [rqi_pkg::ABC_W-1:0] d2_b_ff;
   logic [119:0]  bb_in;
   logic [119:0]  ac_in;
   logic [119:0]  bb_ff;
   logic [121:0]  fac_ff;

   always_comb begin
      bb_in = {bb_hh_ff, 64'd0} + {27'd0, bb_lh_ff, 33'd0} + {56'd0, bb_ll_ff};
      ac_in = {ac_hh_ff, 64'd0} + {28'd0, ac_lh_ff, 32'd0} + {28'd0, ac_hl_ff, 32'd0}
            + {56'd0, ac_ll_ff};
   end

   always_ff @(posedge clock) begin
      d2_valid_ff <= d1_valid_ff && !reset;
      d2_ok_ff    <= d1_ok_ff;
      d2_azero_ff <= d1_azero_ff;
      d2_acneg_ff <= d1_acneg_ff;
      d2_a_ff     <= d1_a_ff;
      d2_b_ff     <= d1_b_ff;
      bb_ff       <= bb_in;
      fac_ff      <= {ac_in, 2'b00};
   end

   // stage 3: discriminant and status
   rqi_pkg::sq_tag_type tag_ff;
   rqi_pkg::sq_tag_type tag_in;
   logic [DW-1:0]       disc_ff;
   logic [DW-1:0]       disc_in;
   logic [DW-1:0]       bb_w;
   logic [DW-1:0]       fac_w;
   logic                miss;

   always_comb begin
      bb_w    = {4'd0, bb_ff};
      fac_w   = {2'd0, fac_ff};
      disc_in = d2_acneg_ff ? (bb_w + fac_w) : (bb_w - fac_w);
      miss    = !d2_acneg_ff && (bb_w < fac_w);
      tag_in.valid = d2_valid_ff && !reset;
      tag_in.a     = d2_a_ff;
      tag_in.b     = d2_b_ff;
      if (!d2_ok_ff) begin
         tag_in.status = rqi_pkg::ST_MISS;
      end else if (d2_azero_ff) begin
         tag_in.status = rqi_pkg::ST_DEGEN;
      end else if (miss) begin
         tag_in.status = rqi_pkg::ST_MISS;
      end else begin
         tag_in.status = rqi_pkg::ST_HIT;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff  <= tag_in;
      disc_ff <= disc_in;
   end

   assign tag  = tag_ff;
   assign disc = disc_ff;

endmodule

### design/rqi_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rqi_sqrt_cell: one digit of the integer square root
// Takes two radicand bits, tries the next root bit and passes the partial
// root, remainder and item tag to the next cell.
// ----------------------------------------------------------------------------
module rqi_sqrt_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  rqi_pkg::sq_tag_type            tag_i,
   input  logic [rqi_pkg::DISC_W-1:0]     x_i,
   input  logic [rqi_pkg::SQ_REM_W-1:0]   rem_i,
   input  logic [rqi_pkg::SQ_W-1:0]       root_i,
   output rqi_pkg::sq_tag_type            tag_o,
   output logic [rqi_pkg::DISC_W-1:0]     x_o,
   output logic [rqi_pkg::SQ_REM_W-1:0]   rem_o,
   output logic [rqi_pkg::SQ_W-1:0]       root_o
);

   localparam int DW = rqi_pkg::DISC_W;
   localparam int RW = rqi_pkg::SQ_REM_W;
   localparam int SW = rqi_pkg::SQ_W;

   rqi_pkg::sq_tag_type tag_ff;
   rqi_pkg::sq_tag_type tag_in;
   logic [DW-1:0]       x_ff;
   logic [RW-1:0]       rem_ff;
   logic [SW-1:0]       root_ff;
   logic [RW-1:0]       rem2;
   logic [RW-1:0]       trial;
   logic                ge;
   logic [RW-1:0]       rem_in;
   logic [SW-1:0]       root_in;

   // try the next root bit
   always_comb begin
      rem2    = {rem_i[RW-3:0], x_i[DW-1:DW-2]};
      trial   = {root_i, 2'b01};
      ge      = (rem2 >= trial);
      rem_in  = ge ? (rem2 - trial) : rem2;
      root_in = {root_i[SW-2:0], ge};
      tag_in       = tag_i;
      tag_in.valid = tag_i.valid && !reset;
   end

   always_ff @(posedge clock) begin
      tag_ff  <= tag_in;
      x_ff    <= {x_i[DW-3:0], 2'b00};
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign tag_o  = tag_ff;
   assign x_o    = x_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule

### design/rqi_div_cell.sv
// ----------------------------------------------------------------------------
// rqi_div_cell: one quotient bit for both roots
// Runs one restoring divide step on the near and far lanes against the
// shared divisor 2|a| and passes everything on.
// ----------------------------------------------------------------------------
module rqi_div_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  rqi_pkg::div_ctl_type        ctl_i,
   input  rqi_pkg::div_pair_type       pair_i,
   input  logic [rqi_pkg::DIV_W-1:0]   d_i,
   output rqi_pkg::div_ctl_type        ctl_o,
   output rqi_pkg::div_pair_type       pair_o,
   output logic [rqi_pkg::DIV_W-1:0]   d_o
);

   rqi_pkg::div_ctl_type        ctl_ff;
   rqi_pkg::div_ctl_type        ctl_in;
   rqi_pkg::div_pair_type       pair_ff;
   rqi_pkg::div_pair_type       pair_in;
   logic [rqi_pkg::DIV_W-1:0]   d_ff;

   // advance both lanes by one bit
   always_comb begin
      pair_in.near = rqi_pkg::div_step(pair_i.near, d_i);
      pair_in.far  = rqi_pkg::div_step(pair_i.far, d_i);
      ctl_in       = ctl_i;
      ctl_in.valid = ctl_i.valid && !reset;
   end

   always_ff @(posedge clock) begin
      ctl_ff  <= ctl_in;
      pair_ff <= pair_in;
      d_ff    <= d_i;
   end

   assign ctl_o  = ctl_ff;
   assign pair_o = pair_ff;
   assign d_o    = d_ff;

endmodule

### design/ray_quadric_intersect.sv
// ----------------------------------------------------------------------------
// ray_quadric_intersect: ray against sphere, y-cylinder or y-cone
// Forms the quadratic of the ray against the object, its discriminant, the
// integer square root and both roots in saturated signed fixed point.
//
//   channel  ports                         transfer
//   -------  ----------------------------  ---------------------------------
//   request  start, busy, req_*            edge with start high, busy low
//   response rsp_valid, rsp_*              one cycle strobe, always taken
//
// One item enters every cycle; busy stays low. The pipeline holds
// 5 coefficient stages, 3 discriminant stages, 62 square-root cells (one
// root bit each), 1 divider setup stage, 32 divider cells (one quotient bit
// each, both roots side by side) and 1 output register. The root and divider
// chains set the latency. Reset clears only the valid flags of the stages.
// ----------------------------------------------------------------------------
module ray_quadric_intersect #(
   parameter int FRAC_BITS = rqi_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_shape,
   input  logic signed [31:0]  req_ctr_x,
   input  logic signed [31:0]  req_ctr_y,
   input  logic signed [31:0]  req_ctr_z,
   input  logic [30:0]         req_shape_coef,
   input  logic signed [31:0]  req_org_x,
   input  logic signed [31:0]  req_org_y,
   input  logic signed [31:0]  req_org_z,
   input  logic signed [31:0]  req_dir_x,
   input  logic signed [31:0]  req_dir_y,
   input  logic signed [31:0]  req_dir_z,
   output logic                rsp_valid,
   output logic [1:0]          rsp_hit_status,
   output logic signed [31:0]  rsp_t_near,
   output logic signed [31:0]  rsp_t_far
);

   localparam int SW    = rqi_pkg::SQ_W;
   localparam int QW    = rqi_pkg::Q_W;
   localparam int DVW   = rqi_pkg::DIV_W;
   localparam int NUM_W = 63 + FRAC_BITS;

   // pipeline never stalls
   assign busy = 1'b0;

   // coefficients and discriminant
   rqi_pkg::abc_type    abc;
   rqi_pkg::sq_tag_type sq_tag [SW+1];
   logic [rqi_pkg::DISC_W-1:0]   sq_x    [SW+1];
   logic [rqi_pkg::SQ_REM_W-1:0] sq_rem  [SW+1];
   logic [SW-1:0]                sq_root [SW+1];

   rqi_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start && !busy),
      .shape      (req_shape),
      .ctr_x      (req_ctr_x),
      .ctr_y      (req_ctr_y),
      .ctr_z      (req_ctr_z),
      .shape_coef (req_shape_coef),
      .org_x      (req_org_x),
      .org_y      (req_org_y),
      .org_z      (req_org_z),
      .dir_x      (req_dir_x),
      .dir_y      (req_dir_y),
      .dir_z      (req_dir_z),
      .abc        (abc)
   );

   rqi_disc u_disc (
      .clock (clock),
      .reset (reset),
      .abc   (abc),
      .tag   (sq_tag[0]),
      .disc  (sq_x[0])
   );

   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   // square root chain
   for (genvar i = 0; i < SW; i++) begin : g_sqrt
      rqi_sqrt_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .tag_i  (sq_tag[i]),
         .x_i    (sq_x[i]),
         .rem_i  (sq_rem[i]),
         .root_i (sq_root[i]),
         .tag_o  (sq_tag[i+1]),
         .x_o    (sq_x[i+1]),
         .rem_o  (sq_rem[i+1]),
         .root_o (sq_root[i+1])
      );
   end

   // divider setup: numerators -b -/+ s, divisor 2|a|, overflow check
   rqi_pkg::sq_tag_type   sq_end;
   logic signed [63:0]    n_w   [2];
   logic [62:0]           n_mag [2];
   logic [NUM_W-1:0]      num   [2];
   logic [DVW-1:0]        hi_w  [2];
   logic [DVW-1:0]        dv_d_in;
   rqi_pkg::div_lane_type lane_in [2];
   rqi_pkg::div_ctl_type  pr_ctl_ff;
   rqi_pkg::div_pair_type pr_pair_ff;
   logic [DVW-1:0]        pr_d_ff;

   always_comb begin
      sq_end  = sq_tag[SW];
      dv_d_in = {1'b0, rqi_pkg::mag_abc(sq_end.a), 1'b0};
      n_w[0]  = -64'($signed(sq_end.b)) - $signed({2'b00, sq_root[SW]});
      n_w[1]  = -64'($signed(sq_end.b)) + $signed({2'b00, sq_root[SW]});
      for (int k = 0; k < 2; k++) begin
         n_mag[k]       = n_w[k][63] ? 63'(-n_w[k]) : 63'(n_w[k]);
         num[k]         = NUM_W'(n_mag[k]) << FRAC_BITS;
         hi_w[k]        = DVW'(num[k][NUM_W-1:QW]);
         lane_in[k].neg = n_w[k][63] ^ sq_end.a[rqi_pkg::ABC_W-1];
         lane_in[k].ovf = (hi_w[k] >= dv_d_in);
         lane_in[k].rem = lane_in[k].ovf ? '0 : hi_w[k];
         lane_in[k].lo  = num[k][QW-1:0];
         lane_in[k].q   = '0;
      end
   end

   always_ff @(posedge clock) begin
      pr_ctl_ff.valid  <= sq_end.valid && !reset;
      pr_ctl_ff.status <= sq_end.status;
      pr_pair_ff.near  <= lane_in[0];
      pr_pair_ff.far   <= lane_in[1];
      pr_d_ff          <= dv_d_in;
   end

   // divider chain
   rqi_pkg::div_ctl_type  dv_ctl  [QW+1];
   rqi_pkg::div_pair_type dv_pair [QW+1];
   logic [DVW-1:0]        dv_d    [QW+1];

   assign dv_ctl[0]  = pr_ctl_ff;
   assign dv_pair[0] = pr_pair_ff;
   assign dv_d[0]    = pr_d_ff;

   for (genvar j = 0; j < QW; j++) begin : g_div
      rqi_div_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl_i  (dv_ctl[j]),
         .pair_i (dv_pair[j]),
         .d_i    (dv_d[j]),
         .ctl_o  (dv_ctl[j+1]),
         .pair_o (dv_pair[j+1]),
         .d_o    (dv_d[j+1])
      );
   end

   // saturate, sign and zero non-hits
   rqi_pkg::div_lane_type fin [2];
   logic [QW-1:0]         t_in [2];
   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff;
   logic [QW-1:0]         rsp_near_ff;
   logic [QW-1:0]         rsp_far_ff;

   always_comb begin
      fin[0] = dv_pair[QW].near;
      fin[1] = dv_pair[QW].far;
      for (int k = 0; k < 2; k++) begin
         if (dv_ctl[QW].status != rqi_pkg::ST_HIT) begin
            t_in[k] = '0;
         end else if (fin[k].neg) begin
            if (fin[k].ovf || (fin[k].q > rqi_pkg::Q_NEG_MAG)) begin
               t_in[k] = rqi_pkg::Q_NEG_MAG;
            end else begin
               t_in[k] = ~fin[k].q + 1'b1;
            end
         end else begin
            if (fin[k].ovf || (fin[k].q > rqi_pkg::Q_POS_MAX)) begin
               t_in[k] = rqi_pkg::Q_POS_MAX;
            end else begin
               t_in[k] = fin[k].q;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_valid_ff  <= dv_ctl[QW].valid && !reset;
      rsp_status_ff <= dv_ctl[QW].status;
      rsp_near_ff   <= t_in[0];
      rsp_far_ff    <= t_in[1];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit_status = rsp_status_ff;
   assign rsp_t_near     = $signed(rsp_near_ff);
   assign rsp_t_far      = $signed(rsp_far_ff);

endmodule

### verif/tb_ray_quadric_intersect.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ray_quadric_intersect: self-checking bench for the ray/quadric unit
// Drives directed and random ray-object pairs through the command port and
// keeps its own wide-integer model of the quadratic, discriminant, root and
// divide. Each strobed response is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_ray_quadric_intersect;

   localparam int         FRAC      = 16;
   localparam int         WD_LIMIT  = 2000;
   localparam int         LATENCY   = 104;
   localparam logic [1:0] SHP_NONE  = 2'd3;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic [1:0]         shape;
      logic signed [31:0] cx, cy, cz;
      logic [30:0]        coef;
      logic signed [31:0] ox, oy, oz;
      logic signed [31:0] dx, dy, dz;
   } ray_obj_type;

   typedef struct {
      logic [1:0]         status;
      logic signed [31:0] t_near;
      logic signed [31:0] t_far;
   } hit_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_shape;
   logic signed [31:0] req_ctr_x, req_ctr_y, req_ctr_z;
   logic [30:0]        req_shape_coef;
   logic signed [31:0] req_org_x, req_org_y, req_org_z;
   logic signed [31:0] req_dir_x, req_dir_y, req_dir_z;
   logic               rsp_valid;
   logic [1:0]         rsp_hit_status;
   logic signed [31:0] rsp_t_near, rsp_t_far;

   hit_type expected_hits[$];
   int      mismatches;
   bit      activity;
   bit      allow_idle;

   ray_quadric_intersect uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_shape(req_shape), .req_ctr_x(req_ctr_x), .req_ctr_y(req_ctr_y),
      .req_ctr_z(req_ctr_z), .req_shape_coef(req_shape_coef),
      .req_org_x(req_org_x), .req_org_y(req_org_y), .req_org_z(req_org_z),
      .req_dir_x(req_dir_x), .req_dir_y(req_dir_y), .req_dir_z(req_dir_z),
      .rsp_valid(rsp_valid), .rsp_hit_status(rsp_hit_status),
      .rsp_t_near(rsp_t_near), .rsp_t_far(rsp_t_far)
   );

   // 4 ns clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // clamp a coefficient to the 60-bit magnitude range
   function automatic wide_type clamp_coef(input wide_type x);
      wide_type lim;
      lim = (wide_type'(1) <<< 60) - 1;
      if (x > lim) return lim;
      if (x < -lim) return -lim;
      return x;
   endfunction

   // fixed-point product, floor rounded, clamped
   function automatic wide_type fx_mul(input wide_type x, input wide_type y);
      wide_type p;
      p = (x * y) >>> FRAC;
      return clamp_coef(p);
   endfunction

   // floor square root of the discriminant
   function automatic logic [63:0] floor_sqrt(input logic [127:0] x);
      logic [63:0]  rt;
      logic [63:0]  cnd;
      logic [127:0] sq;
      rt = '0;
      for (int i = 63; i >= 0; i--) begin
         cnd = rt | (64'd1 << i);
         sq  = {64'd0, cnd} * {64'd0, cnd};
         if (sq <= x) rt = cnd;
      end
      return rt;
   endfunction

   // one root: (n << FRAC) / (2a), truncated and saturated to 32 bits
   function automatic logic signed [31:0] root_div(input wide_type n, input wide_type a);
      logic [127:0] nm;
      logic [127:0] am;
      logic [127:0] q;
      logic         neg;
      neg = (n < 0) != (a < 0);
      nm  = (n < 0) ? -n : n;
      am  = (a < 0) ? -a : a;
      q   = (nm << FRAC) / (am << 1);
      if (neg) begin
         if (q > 128'h8000_0000) return 32'sh8000_0000;
         return -q[31:0];
      end
      if (q > 128'h7FFF_FFFF) return 32'sh7FFF_FFFF;
      return q[31:0];
   endfunction

   // expected intersection for one ray-object pair
   function automatic hit_type predict_hit(input ray_obj_type r);
      wide_type vx, vy, vz, dx, dy, dz, cf, a, b, c, disc, s;
      hit_type  h;
      h  = '{rqi_pkg::ST_MISS, 32'sd0, 32'sd0};
      vx = r.ox; vy = r.oy; vz = r.oz;
      dx = r.cx; vx = vx - dx;
      dx = r.cy; vy = vy - dx;
      dx = r.cz; vz = vz - dx;
      dx = r.dx; dy = r.dy; dz = r.dz;
      cf = {97'd0, r.coef};
      case (r.shape)
         rqi_pkg::SHP_SPHERE: begin
            a = fx_mul(dx, dx) + fx_mul(dy, dy) + fx_mul(dz, dz);
            b = fx_mul(dx, vx) + fx_mul(dy, vy) + fx_mul(dz, vz);
            c = fx_mul(vx, vx) + fx_mul(vy, vy) + fx_mul(vz, vz) - cf;
         end
         rqi_pkg::SHP_CYL: begin
            a = fx_mul(dx, dx) + fx_mul(dz, dz);
            b = fx_mul(dx, vx) + fx_mul(dz, vz);
            c = fx_mul(vx, vx) + fx_mul(vz, vz) - cf;
         end
         rqi_pkg::SHP_CONE: begin
            a = fx_mul(dx, dx) + fx_mul(dz, dz) - fx_mul(cf, fx_mul(dy, dy));
            b = fx_mul(dx, vx) + fx_mul(dz, vz) - fx_mul(cf, fx_mul(dy, vy));
            c = fx_mul(vx, vx) + fx_mul(vz, vz) - fx_mul(cf, fx_mul(vy, vy));
         end
         default: return h;
      endcase
      a = clamp_coef(a);
      b = clamp_coef(2 * b);
      c = clamp_coef(c);
      if (a == 0) begin
         h.status = rqi_pkg::ST_DEGEN;
         return h;
      end
      disc = b * b - 4 * a * c;
      if (disc < 0) return h;
      s = {64'd0, floor_sqrt(disc)};
      h.status = rqi_pkg::ST_HIT;
      h.t_near = root_div(-b - s, a);
      h.t_far  = root_div(-b + s, a);
      return h;
   endfunction

   // send one pair; called and returns just after a falling edge
   task automatic send_ray(input ray_obj_type r);
      req_shape = r.shape;
      req_ctr_x = r.cx; req_ctr_y = r.cy; req_ctr_z = r.cz;
      req_shape_coef = r.coef;
      req_org_x = r.ox; req_org_y = r.oy; req_org_z = r.oz;
      req_dir_x = r.dx; req_dir_y = r.dy; req_dir_z = r.dz;
      start = 1'b1;
      while (busy) @(negedge clock);
      @(posedge clock);
      expected_hits.push_back(predict_hit(r));
      activity = 1'b1;
      @(negedge clock);
      if (allow_idle && $urandom_range(0, 7) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
   endtask

   function automatic ray_obj_type make_ray(input logic [1:0] shp,
                                            input int cx, input int cy, input int cz,
                                            input int cf,
                                            input int ox, input int oy, input int oz,
                                            input int dx, input int dy, input int dz);
      ray_obj_type r;
      r.shape = shp; r.cx = cx; r.cy = cy; r.cz = cz; r.coef = cf[30:0];
      r.ox = ox; r.oy = oy; r.oz = oz; r.dx = dx; r.dy = dy; r.dz = dz;
      return r;
   endfunction

   // small scene-like values, or fully random bits
   function automatic logic signed [31:0] rand_coord(input bit wild, input int span);
      if (wild) return $urandom;
      return $signed($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic ray_obj_type rand_ray(input bit wild);
      ray_obj_type r;
      r.shape = $urandom_range(0, 15) == 0 ? SHP_NONE : 2'($urandom_range(0, 2));
      r.cx = rand_coord(wild, 8 << FRAC); r.cy = rand_coord(wild, 8 << FRAC);
      r.cz = rand_coord(wild, 8 << FRAC);
      r.ox = rand_coord(wild, 8 << FRAC); r.oy = rand_coord(wild, 8 << FRAC);
      r.oz = rand_coord(wild, 8 << FRAC);
      r.dx = rand_coord(wild, 2 << FRAC); r.dy = rand_coord(wild, 2 << FRAC);
      r.dz = rand_coord(wild, 2 << FRAC);
      r.coef = wild ? 31'($urandom) : 31'($urandom_range(0, 16 << FRAC));
      return r;
   endfunction

   // hold the sender until every pending result has come back
   task automatic drain_results();
      start = 1'b0;
      while (expected_hits.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      localparam int ONE = 1 << FRAC;
      send_ray(make_ray(rqi_pkg::SHP_SPHERE, 0, 0, 0, ONE, 0, 0, -5 * ONE, 0, 0, ONE));
      send_ray(make_ray(rqi_pkg::SHP_SPHERE, 0, 0, 0, ONE, 0, 3 * ONE, -5 * ONE, 0, 0, ONE));
      send_ray(make_ray(rqi_pkg::SHP_SPHERE, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0));
      send_ray(make_ray(rqi_pkg::SHP_SPHERE, 0, 0, 0, 0, 0, 0, 0, ONE, 0, 0));
      send_ray(make_ray(rqi_pkg::SHP_CYL, ONE, 0, 0, 4 * ONE, -6 * ONE, 2 * ONE, 0,
                        ONE, 0, 0));
      send_ray(make_ray(rqi_pkg::SHP_CYL, 0, 0, 0, ONE, 0, 0, 0, 0, ONE, 0));
      send_ray(make_ray(rqi_pkg::SHP_CONE, 0, 0, 0, ONE, -4 * ONE, ONE, 0, ONE, 0, 0));
      send_ray(make_ray(rqi_pkg::SHP_CONE, 0, 0, 0, 4 * ONE, 0, -3 * ONE, ONE / 2,
                        0, ONE, 0));
      send_ray(make_ray(rqi_pkg::SHP_CONE, 0, 0, 0, ONE, 0, 0, 0, ONE, ONE, 0));
      send_ray(make_ray(SHP_NONE, 0, 0, 0, ONE, 0, 0, -5 * ONE, 0, 0, ONE));
      send_ray(make_ray(rqi_pkg::SHP_SPHERE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_ray(make_ray(rqi_pkg::SHP_CYL, 32'h8000_0000, 0, 32'h8000_0000, 0,
                        32'h7FFF_FFFF, 0, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send_ray(make_ray(rqi_pkg::SHP_CONE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h8000_0000, 0, 1, 32'h7FFF_FFFF, -1));
      send_ray(make_ray(rqi_pkg::SHP_SPHERE, 0, 0, 0, ONE, 0, 0, -5 * ONE, 0, 0, 1));
      send_ray(make_ray(rqi_pkg::SHP_SPHERE, 0, 0, 0, ONE, 0, 0, 0, 0, 0, ONE));
      send_ray(make_ray(rqi_pkg::SHP_SPHERE, 0, 0, 0, ONE, ONE, 0, -5 * ONE, 0, 0, ONE));
      send_ray(make_ray(rqi_pkg::SHP_CYL, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 1, 0, 1));
      send_ray(make_ray(rqi_pkg::SHP_CONE, 0, 0, 0, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE));
      send_ray(make_ray(rqi_pkg::SHP_SPHERE, -1, -1, -1, 1, 1, 1, 1, -1, -1, -1));
   endtask

   task automatic test_random(input int count, input int wild_pct);
      for (int i = 0; i < count; i++) begin
         send_ray(rand_ray($urandom_range(0, 99) < wild_pct));
      end
   endtask

   task automatic test_back_to_back(input int count);
      allow_idle = 1'b0;
      for (int i = 0; i < count; i++) begin
         send_ray(rand_ray($urandom_range(0, 3) == 0));
      end
   endtask

   // check each strobed result against the oldest prediction
   always @(posedge clock) begin
      hit_type h;
      if (!reset && rsp_valid) begin
         activity = 1'b1;
         if (expected_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result status=%0d", rsp_hit_status);
         end else begin
            h = expected_hits.pop_front();
            if (rsp_hit_status !== h.status || rsp_t_near !== h.t_near ||
                rsp_t_far !== h.t_far) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st=%0d near=%h far=%h got st=%0d near=%h far=%h",
                           h.status, h.t_near, h.t_far,
                           rsp_hit_status, rsp_t_near, rsp_t_far);
            end
         end
      end
   end

   // watchdog: end the run when nothing transfers for too long
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(negedge clock);
         if (activity || reset) quiet = 0;
         else quiet++;
         activity = 1'b0;
         if (quiet >= WD_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      mismatches = 0;
      activity   = 1'b0;
      allow_idle = 1'b1;
      reset = 1'b1;
      start = 1'b0;
      req_shape = '0;
      req_ctr_x = '0; req_ctr_y = '0; req_ctr_z = '0;
      req_shape_coef = '0;
      req_org_x = '0; req_org_y = '0; req_org_z = '0;
      req_dir_x = '0; req_dir_y = '0; req_dir_z = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(500, 20);
      drain_results();
      test_random(500, 40);
      test_back_to_back(250);

      // let the pipeline empty, then settle
      drain_results();
      repeat (LATENCY + 10) @(negedge clock);
      if (mismatches == 0 && expected_hits.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### ray_quadric_intersect.f
design/rqi_pkg.sv
design/rqi_front.sv
design/rqi_disc.sv
design/rqi_sqrt_cell.sv
design/rqi_div_cell.sv
design/ray_quadric_intersect.sv
verif/tb_ray_quadric_intersect.sv
